// File: hdl/iec104_pkg.sv
// Package for the IEC 104 APCI link engine: codes, constants, helper functions.
// No dependencies.
package iec104_pkg;

    localparam int SEQ_W  = 15;
    localparam int TIME_W = 32;
    localparam int TCFG_W = 18;
    localparam int MAX_PAYLOAD = 249;

    localparam logic [2:0] REQ_RX    = 3'd0;
    localparam logic [2:0] REQ_SEND_I = 3'd1;
    localparam logic [2:0] REQ_SEND_S = 3'd2;
    localparam logic [2:0] REQ_SEND_U = 3'd3;
    localparam logic [2:0] REQ_TIMER = 3'd4;
    localparam logic [2:0] REQ_RESET = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MALF   = 2'd1;
    localparam logic [1:0] ST_ORDER  = 2'd2;
    localparam logic [1:0] ST_WINDOW = 2'd3;

    localparam logic [1:0] FT_I = 2'd0;
    localparam logic [1:0] FT_S = 2'd1;
    localparam logic [1:0] FT_U = 2'd2;

    localparam logic [2:0] CFG_K  = 3'd0;
    localparam logic [2:0] CFG_W  = 3'd1;
    localparam logic [2:0] CFG_T1 = 3'd2;
    localparam logic [2:0] CFG_T2 = 3'd3;
    localparam logic [2:0] CFG_T3 = 3'd4;

    localparam logic [7:0] START_OCTET = 8'h68;
    localparam logic [TCFG_W-1:0] TIME_LIMIT = 18'd255000;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic [7:0]  rx_start;
        logic [7:0]  rx_length;
        logic [31:0] rx_control;
        logic [7:0]  tx_asdu_length;
        logic [7:0]  tx_function;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  frame_type;
        logic [14:0] peer_send_seq;
        logic [14:0] peer_recv_seq;
        logic [7:0]  peer_function;
        logic [47:0] apci_out;
        logic [8:0]  frame_total;
        logic        window_open;
        logic        ack_due;
        logic        test_due;
        logic        confirm_overdue;
        logic [14:0] outstanding_count;
    } t_res;

    // effective (clamped) configuration
    typedef struct packed {
        logic [SEQ_W-1:0]  k;
        logic [SEQ_W-1:0]  w;
        logic [TCFG_W-1:0] t1;
        logic [TCFG_W-1:0] t2;
        logic [TCFG_W-1:0] t3;
    } t_cfg;

    function automatic logic known_function(input logic [7:0] f);
        return f == 8'h07 || f == 8'h0B || f == 8'h13 || f == 8'h23 ||
               f == 8'h43 || f == 8'h83;
    endfunction

    function automatic logic is_confirm(input logic [7:0] f);
        return f == 8'h0B || f == 8'h23 || f == 8'h83;
    endfunction

    function automatic logic [SEQ_W-1:0] read_seq(input logic [7:0] lo, input logic [7:0] hi);
        return {hi, lo[7:1]};
    endfunction

    function automatic logic [15:0] seq_octets(input logic [SEQ_W-1:0] v);
        return {v[14:7], v[6:0], 1'b0};
    endfunction

endpackage

// File: hdl/iec104_stream_if.sv
// Valid/ready channel carrying one payload of a given type.
// No dependencies; iec104_pkg types are passed in through the type parameter.
interface iec104_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/iec104_cfg.sv
// Configuration registers and their clamped effective values.
// Depends on iec104_pkg.
module iec104_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [17:0]                i_cfg_data,
    output iec104_pkg::t_cfg           o_cfg
);
    logic [14:0] r_k, r_w;
    logic [17:0] r_t1, r_t2, r_t3;
    logic [14:0] k_eff;
    logic [17:0] t1_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= 15'd12;
            r_w  <= 15'd8;
            r_t1 <= 18'd15000;
            r_t2 <= 18'd10000;
            r_t3 <= 18'd20000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iec104_pkg::CFG_K:  r_k  <= i_cfg_data[14:0];
                iec104_pkg::CFG_W:  r_w  <= i_cfg_data[14:0];
                iec104_pkg::CFG_T1: r_t1 <= i_cfg_data;
                iec104_pkg::CFG_T2: r_t2 <= i_cfg_data;
                iec104_pkg::CFG_T3: r_t3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        k_eff  = (r_k == '0) ? 15'd1 : r_k;
        t1_eff = (r_t1 == '0) ? 18'd1 :
                 (r_t1 > iec104_pkg::TIME_LIMIT) ? iec104_pkg::TIME_LIMIT : r_t1;
        o_cfg.k  = k_eff;
        o_cfg.w  = (r_w == '0) ? 15'd1 : (r_w > k_eff) ? k_eff : r_w;
        o_cfg.t1 = t1_eff;
        o_cfg.t2 = (r_t2 == '0) ? 18'd1 : (r_t2 > t1_eff) ? t1_eff : r_t2;
        o_cfg.t3 = (r_t3 == '0) ? 18'd1 :
                   (r_t3 > iec104_pkg::TIME_LIMIT) ? iec104_pkg::TIME_LIMIT : r_t3;
    end
endmodule

// File: hdl/iec104_core.sv
// Link state and single-pass request processing with registered input and result.
// Depends on iec104_pkg.
module iec104_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iec104_pkg::t_cfg  i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  iec104_pkg::t_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output iec104_pkg::t_res  o_out_data
);
    logic             r_req_v;
    iec104_pkg::t_req r_req;
    logic             r_res_v;
    iec104_pkg::t_res r_res;

    logic [14:0] r_nss, r_ers, r_pas, r_urc;
    logic [31:0] r_lt_t, r_fu_t, r_sp_t, r_cp_t;
    logic        r_lt_a, r_fu_a, r_sp_a, r_cp_a;

    logic [14:0] n_nss, n_ers, n_pas, n_urc;
    logic [31:0] n_lt_t, n_fu_t, n_sp_t, n_cp_t;
    logic        n_lt_a, n_fu_a, n_sp_a, n_cp_a;
    iec104_pkg::t_res n_res;

    logic stage_go, res_free;

    assign res_free    = !r_res_v || i_out_ready;
    assign stage_go    = r_req_v && res_free;
    assign o_in_ready  = !r_req_v || res_free;
    assign o_out_valid = r_res_v;
    assign o_out_data  = r_res;

    always_comb begin
        logic [7:0]  c0, c1, c2, c3, rlen;
        logic [14:0] pss, prs, adv, pend, outs;
        logic [31:0] now;
        logic        ack_ok;
        c0 = r_req.rx_control[7:0];
        c1 = r_req.rx_control[15:8];
        c2 = r_req.rx_control[23:16];
        c3 = r_req.rx_control[31:24];
        rlen = r_req.rx_length;
        now  = r_req.now_ms;
        pss  = iec104_pkg::read_seq(c0, c1);
        prs  = iec104_pkg::read_seq(c2, c3);
        pend = r_nss - r_pas;
        adv  = prs - r_pas;
        ack_ok = adv <= pend;

        n_nss = r_nss; n_ers = r_ers; n_pas = r_pas; n_urc = r_urc;
        n_lt_t = r_lt_t; n_fu_t = r_fu_t; n_sp_t = r_sp_t; n_cp_t = r_cp_t;
        n_lt_a = r_lt_a; n_fu_a = r_fu_a; n_sp_a = r_sp_a; n_cp_a = r_cp_a;
        n_res = '0;

        case (r_req.req_type)
            iec104_pkg::REQ_RX: begin
                if (r_req.rx_start != iec104_pkg::START_OCTET || rlen < 8'd4 ||
                    rlen > 8'(iec104_pkg::MAX_PAYLOAD + 4)) begin
                    n_res.status = iec104_pkg::ST_MALF;
                end else begin
                    n_res.frame_total = {1'b0, rlen} + 9'd2;
                    n_lt_a = 1'b1;
                    n_lt_t = now;
                    if (!c0[0]) begin
                        n_res.frame_type    = iec104_pkg::FT_I;
                        n_res.peer_send_seq = pss;
                        n_res.peer_recv_seq = prs;
                        if (pss != r_ers || !ack_ok) begin
                            n_res.status = iec104_pkg::ST_ORDER;
                        end else begin
                            n_pas = prs;
                            if (prs == r_nss) begin
                                n_sp_a = 1'b0; n_sp_t = '0;
                            end else if (adv != '0) begin
                                n_sp_a = 1'b1; n_sp_t = now;
                            end
                            n_ers = r_ers + 15'd1;
                            if (r_urc == '0) begin
                                n_fu_a = 1'b1; n_fu_t = now;
                            end
                            if (r_urc != 15'h7FFF) n_urc = r_urc + 15'd1;
                        end
                    end else if (c0[1:0] == 2'b01) begin
                        if (rlen != 8'd4) begin
                            n_res.status = iec104_pkg::ST_MALF;
                        end else begin
                            n_res.frame_type    = iec104_pkg::FT_S;
                            n_res.peer_recv_seq = prs;
                            if (!ack_ok) begin
                                n_res.status = iec104_pkg::ST_ORDER;
                            end else begin
                                n_pas = prs;
                                if (prs == r_nss) begin
                                    n_sp_a = 1'b0; n_sp_t = '0;
                                end else if (adv != '0) begin
                                    n_sp_a = 1'b1; n_sp_t = now;
                                end
                            end
                        end
                    end else begin
                        if (rlen != 8'd4 || !iec104_pkg::known_function(c0)) begin
                            n_res.status = iec104_pkg::ST_MALF;
                        end else begin
                            n_res.frame_type    = iec104_pkg::FT_U;
                            n_res.peer_function = c0;
                            if (iec104_pkg::is_confirm(c0)) begin
                                n_cp_a = 1'b0; n_cp_t = '0;
                            end
                        end
                    end
                end
            end
            iec104_pkg::REQ_SEND_I: begin
                n_res.frame_type = iec104_pkg::FT_I;
                if (r_req.tx_asdu_length == '0 ||
                    r_req.tx_asdu_length > 8'(iec104_pkg::MAX_PAYLOAD)) begin
                    n_res.status = iec104_pkg::ST_MALF;
                end else if (pend >= i_cfg.k) begin
                    n_res.status = iec104_pkg::ST_WINDOW;
                end else begin
                    n_res.apci_out = {iec104_pkg::seq_octets(r_ers),
                                      iec104_pkg::seq_octets(r_nss),
                                      r_req.tx_asdu_length + 8'd4,
                                      iec104_pkg::START_OCTET};
                    n_res.frame_total = {1'b0, r_req.tx_asdu_length} + 9'd6;
                    n_nss = r_nss + 15'd1;
                    if (!r_sp_a) begin
                        n_sp_a = 1'b1; n_sp_t = now;
                    end
                    n_urc = '0; n_fu_a = 1'b0; n_fu_t = '0;
                    n_lt_a = 1'b1; n_lt_t = now;
                end
            end
            iec104_pkg::REQ_SEND_S: begin
                n_res.frame_type = iec104_pkg::FT_S;
                n_res.apci_out = {iec104_pkg::seq_octets(r_ers), 16'h0001, 8'd4,
                                  iec104_pkg::START_OCTET};
                n_res.frame_total = 9'd6;
                n_urc = '0; n_fu_a = 1'b0; n_fu_t = '0;
                n_lt_a = 1'b1; n_lt_t = now;
            end
            iec104_pkg::REQ_SEND_U: begin
                n_res.frame_type = iec104_pkg::FT_U;
                if (!iec104_pkg::known_function(r_req.tx_function)) begin
                    n_res.status = iec104_pkg::ST_MALF;
                end else begin
                    n_res.apci_out = {16'h0000, 8'h00, r_req.tx_function, 8'd4,
                                      iec104_pkg::START_OCTET};
                    n_res.frame_total = 9'd6;
                    if (!iec104_pkg::is_confirm(r_req.tx_function) && !r_cp_a) begin
                        n_cp_a = 1'b1; n_cp_t = now;
                    end
                    n_lt_a = 1'b1; n_lt_t = now;
                end
            end
            iec104_pkg::REQ_RESET: begin
                n_nss = '0; n_ers = '0; n_pas = '0; n_urc = '0;
                n_lt_a = 1'b1; n_lt_t = now;
                n_fu_a = 1'b0; n_sp_a = 1'b0; n_cp_a = 1'b0;
                n_fu_t = '0; n_sp_t = '0; n_cp_t = '0;
            end
            default: ;
        endcase

        // flags are evaluated on the updated state
        outs = n_nss - n_pas;
        n_res.outstanding_count = outs;
        n_res.window_open = outs < i_cfg.k;
        n_res.ack_due = (n_urc != '0) && ((n_urc >= i_cfg.w) ||
                        (n_fu_a && (now - n_fu_t) >= {14'd0, i_cfg.t2}));
        n_res.test_due = n_lt_a && !n_cp_a && (now - n_lt_t) >= {14'd0, i_cfg.t3};
        n_res.confirm_overdue = (n_sp_a && (now - n_sp_t) >= {14'd0, i_cfg.t1}) ||
                                (n_cp_a && (now - n_cp_t) >= {14'd0, i_cfg.t1});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_v <= 1'b0;
            r_res_v <= 1'b0;
            r_nss <= '0; r_ers <= '0; r_pas <= '0; r_urc <= '0;
            r_lt_t <= '0; r_fu_t <= '0; r_sp_t <= '0; r_cp_t <= '0;
            r_lt_a <= 1'b0; r_fu_a <= 1'b0; r_sp_a <= 1'b0; r_cp_a <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_req_v <= i_in_valid;
                r_req   <= i_in_data;
            end
            if (stage_go) begin
                r_res_v <= 1'b1;
                r_res   <= n_res;
                r_nss <= n_nss; r_ers <= n_ers; r_pas <= n_pas; r_urc <= n_urc;
                r_lt_t <= n_lt_t; r_fu_t <= n_fu_t; r_sp_t <= n_sp_t; r_cp_t <= n_cp_t;
                r_lt_a <= n_lt_a; r_fu_a <= n_fu_a; r_sp_a <= n_sp_a; r_cp_a <= n_cp_a;
            end else if (i_out_ready) begin
                r_res_v <= 1'b0;
            end
        end
    end
endmodule

// File: hdl/iec104_apci_link_engine.sv
// Top level of the IEC 104 APCI link engine.
// Depends on iec104_pkg, iec104_stream_if, iec104_cfg and iec104_core.
//
// Usage:
//   Requests enter on the input channel (valid/ready, payload t_req); one
//   result per request leaves on the output channel (payload t_res).
//   The result passes through the input register, then the single-pass
//   update into the result register.
//   Throughput is one request per cycle while the receiver does not stall;
//   the link state registers are written together with the result register.
//   If the receiver stalls, the result register holds and the input register
//   fills; ready drops only when both hold an item.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while
//   no request is in flight; values are clamped where used.
//   Reset (synchronous, i_rst_n low) clears link state, timers and both
//   registers, and loads the default k, w, t1, t2 and t3.
module iec104_apci_link_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data,
    iec104_stream_if.sink   i_req,
    iec104_stream_if.source o_res
);
    iec104_pkg::t_cfg cfg;

    iec104_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iec104_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_in_data   (i_req.data),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_data  (o_res.data)
    );
endmodule

// File: bench/iec104_apci_link_engine_tb.sv
// Self-checking bench for iec104_apci_link_engine: directed then random requests,
// predicted by an in-bench model of the APCI link state. Needs iec104_pkg,
// iec104_stream_if and the engine RTL.
module iec104_apci_link_engine_tb;

    localparam int WATCHDOG = 20000;

    // Predicted link state and expected results, checked in transfer order.
    class link_scoreboard;
        logic [14:0] cfg_k, cfg_w;
        logic [17:0] cfg_t1, cfg_t2, cfg_t3;
        logic [14:0] send_seq, recv_seq, acked_seq, rx_unacked;
        logic [31:0] traffic_t, unacked_t, sendp_t, ctrlp_t;
        bit traffic_on, unacked_on, sendp_on, ctrlp_on;
        iec104_pkg::t_res pending[$];
        int errors;

        function void clear_link();
            send_seq = 0; recv_seq = 0; acked_seq = 0; rx_unacked = 0;
            traffic_t = 0; unacked_t = 0; sendp_t = 0; ctrlp_t = 0;
            traffic_on = 0; unacked_on = 0; sendp_on = 0; ctrlp_on = 0;
        endfunction

        function void power_on();
            cfg_k = 12; cfg_w = 8; cfg_t1 = 15000; cfg_t2 = 10000; cfg_t3 = 20000;
            clear_link();
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [17:0] v);
            case (idx)
                iec104_pkg::CFG_K:  cfg_k = v[14:0];
                iec104_pkg::CFG_W:  cfg_w = v[14:0];
                iec104_pkg::CFG_T1: cfg_t1 = v;
                iec104_pkg::CFG_T2: cfg_t2 = v;
                iec104_pkg::CFG_T3: cfg_t3 = v;
                default: ;
            endcase
        endfunction

        function logic [14:0] in_flight();
            return send_seq - acked_seq;
        endfunction

        function logic [14:0] seq_of(logic [7:0] lo, logic [7:0] hi);
            return {hi, lo[7:1]};
        endfunction

        function logic [15:0] seq_bytes(logic [14:0] v);
            return {v[14:7], v[6:0], 1'b0};
        endfunction

        function bit u_known(logic [7:0] f);
            return f == 8'h07 || f == 8'h0B || f == 8'h13 || f == 8'h23 ||
                   f == 8'h43 || f == 8'h83;
        endfunction

        function bit u_confirm(logic [7:0] f);
            return f == 8'h0B || f == 8'h23 || f == 8'h83;
        endfunction

        function bit apply_ack(logic [14:0] rseq, logic [31:0] now);
            logic [14:0] adv;
            adv = rseq - acked_seq;
            if (adv > in_flight()) return 0;
            acked_seq = rseq;
            if (in_flight() == 0) begin
                sendp_on = 0; sendp_t = 0;
            end else if (adv > 0) begin
                sendp_on = 1; sendp_t = now;
            end
            return 1;
        endfunction

        function void note_request(iec104_pkg::t_req q);
            iec104_pkg::t_res r;
            int unsigned k, w, t1, t2, t3;
            logic [7:0] c0, c1, c2, c3;
            logic [31:0] now;
            r = '0;
            now = q.now_ms;
            k = (cfg_k == 0) ? 1 : cfg_k;
            w = (cfg_w == 0) ? 1 : ((cfg_w > k) ? k : cfg_w);
            t1 = (cfg_t1 == 0) ? 1 : ((cfg_t1 > 255000) ? 255000 : cfg_t1);
            t2 = (cfg_t2 == 0) ? 1 : ((cfg_t2 > t1) ? t1 : cfg_t2);
            t3 = (cfg_t3 == 0) ? 1 : ((cfg_t3 > 255000) ? 255000 : cfg_t3);
            {c3, c2, c1, c0} = q.rx_control;
            case (q.req_type)
                iec104_pkg::REQ_RX: begin
                    if (q.rx_start != iec104_pkg::START_OCTET || q.rx_length < 4 ||
                        q.rx_length > iec104_pkg::MAX_PAYLOAD + 4) begin
                        r.status = iec104_pkg::ST_MALF;
                    end else begin
                        r.frame_total = q.rx_length + 9'd2;
                        traffic_on = 1; traffic_t = now;
                        if (!c0[0]) begin
                            r.frame_type = iec104_pkg::FT_I;
                            r.peer_send_seq = seq_of(c0, c1);
                            r.peer_recv_seq = seq_of(c2, c3);
                            if (r.peer_send_seq != recv_seq || !apply_ack(r.peer_recv_seq, now))
                                r.status = iec104_pkg::ST_ORDER;
                            else begin
                                recv_seq++;
                                if (rx_unacked == 0) begin
                                    unacked_on = 1; unacked_t = now;
                                end
                                if (rx_unacked != 15'h7FFF) rx_unacked++;
                            end
                        end else if (c0[1:0] == 2'b01) begin
                            if (q.rx_length != 4) r.status = iec104_pkg::ST_MALF;
                            else begin
                                r.frame_type = iec104_pkg::FT_S;
                                r.peer_recv_seq = seq_of(c2, c3);
                                if (!apply_ack(r.peer_recv_seq, now))
                                    r.status = iec104_pkg::ST_ORDER;
                            end
                        end else begin
                            if (q.rx_length != 4 || !u_known(c0)) r.status = iec104_pkg::ST_MALF;
                            else begin
                                r.frame_type = iec104_pkg::FT_U;
                                r.peer_function = c0;
                                if (u_confirm(c0)) begin
                                    ctrlp_on = 0; ctrlp_t = 0;
                                end
                            end
                        end
                    end
                end
                iec104_pkg::REQ_SEND_I: begin
                    r.frame_type = iec104_pkg::FT_I;
                    if (q.tx_asdu_length == 0 || q.tx_asdu_length > iec104_pkg::MAX_PAYLOAD)
                        r.status = iec104_pkg::ST_MALF;
                    else if (in_flight() >= k)
                        r.status = iec104_pkg::ST_WINDOW;
                    else begin
                        r.apci_out = {seq_bytes(recv_seq), seq_bytes(send_seq),
                                      q.tx_asdu_length + 8'd4, iec104_pkg::START_OCTET};
                        r.frame_total = q.tx_asdu_length + 9'd6;
                        send_seq++;
                        if (!sendp_on) begin
                            sendp_on = 1; sendp_t = now;
                        end
                        rx_unacked = 0; unacked_on = 0; unacked_t = 0;
                        traffic_on = 1; traffic_t = now;
                    end
                end
                iec104_pkg::REQ_SEND_S: begin
                    r.frame_type = iec104_pkg::FT_S;
                    r.apci_out = {seq_bytes(recv_seq), 16'h0001, 8'd4, iec104_pkg::START_OCTET};
                    r.frame_total = 6;
                    rx_unacked = 0; unacked_on = 0; unacked_t = 0;
                    traffic_on = 1; traffic_t = now;
                end
                iec104_pkg::REQ_SEND_U: begin
                    r.frame_type = iec104_pkg::FT_U;
                    if (!u_known(q.tx_function)) r.status = iec104_pkg::ST_MALF;
                    else begin
                        r.apci_out = {24'h0, q.tx_function, 8'd4, iec104_pkg::START_OCTET};
                        r.frame_total = 6;
                        if (!u_confirm(q.tx_function) && !ctrlp_on) begin
                            ctrlp_on = 1; ctrlp_t = now;
                        end
                        traffic_on = 1; traffic_t = now;
                    end
                end
                iec104_pkg::REQ_RESET: begin
                    clear_link();
                    traffic_on = 1; traffic_t = now;
                end
                default: ;
            endcase
            r.outstanding_count = in_flight();
            r.window_open = in_flight() < k;
            r.ack_due = rx_unacked > 0 && (rx_unacked >= w ||
                        (unacked_on && (now - unacked_t) >= t2));
            r.test_due = traffic_on && !ctrlp_on && (now - traffic_t) >= t3;
            r.confirm_overdue = (sendp_on && (now - sendp_t) >= t1) ||
                                (ctrlp_on && (now - ctrlp_t) >= t1);
            pending.push_back(r);
        endfunction

        task check_result(iec104_pkg::t_res got);
            iec104_pkg::t_res exp;
            if (pending.size() == 0) begin
                report("result with nothing expected", 0, 0);
                return;
            end
            exp = pending.pop_front();
            if (got.status != exp.status) report("status", got.status, exp.status);
            if (got.frame_type != exp.frame_type)
                report("frame_type", got.frame_type, exp.frame_type);
            if (got.peer_send_seq != exp.peer_send_seq)
                report("peer_send_seq", got.peer_send_seq, exp.peer_send_seq);
            if (got.peer_recv_seq != exp.peer_recv_seq)
                report("peer_recv_seq", got.peer_recv_seq, exp.peer_recv_seq);
            if (got.peer_function != exp.peer_function)
                report("peer_function", got.peer_function, exp.peer_function);
            if (got.apci_out != exp.apci_out) report("apci_out", got.apci_out, exp.apci_out);
            if (got.frame_total != exp.frame_total)
                report("frame_total", got.frame_total, exp.frame_total);
            if (got.window_open != exp.window_open)
                report("window_open", got.window_open, exp.window_open);
            if (got.ack_due != exp.ack_due) report("ack_due", got.ack_due, exp.ack_due);
            if (got.test_due != exp.test_due) report("test_due", got.test_due, exp.test_due);
            if (got.confirm_overdue != exp.confirm_overdue)
                report("confirm_overdue", got.confirm_overdue, exp.confirm_overdue);
            if (got.outstanding_count != exp.outstanding_count)
                report("outstanding_count", got.outstanding_count, exp.outstanding_count);
        endtask

        task report(string what, logic [47:0] got, logic [47:0] exp);
            errors++;
            if (errors <= 40) $display("mismatch %s: got %0h, expected %0h", what, got, exp);
        endtask
    endclass

    logic i_clk, i_rst_n, i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [17:0] i_cfg_data;

    iec104_stream_if #(.t_payload(iec104_pkg::t_req)) req_if ();
    iec104_stream_if #(.t_payload(iec104_pkg::t_res)) res_if ();

    iec104_apci_link_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req(req_if.sink), .o_res(res_if.source)
    );

    link_scoreboard link_sb;
    int src_idle_pct, snk_stall_pct, quiet_cycles;
    logic [31:0] clock_ms;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: random stall, check on transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 0;
        end else begin
            if (res_if.valid && res_if.ready) link_sb.check_result(res_if.data);
            res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high across back-to-back transfers; it drops only while idling or draining
    task automatic send_req(iec104_pkg::t_req q);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 0;
            @(posedge i_clk);
        end
        req_if.valid <= 1;
        req_if.data <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        link_sb.note_request(q);
    endtask

    task automatic drain();
        req_if.valid <= 0;
        while (link_sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [17:0] v);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        link_sb.write_reg(idx, v);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic iec104_pkg::t_req blank_req(logic [2:0] kind);
        iec104_pkg::t_req q;
        q = '0;
        q.req_type = kind;
        q.now_ms = clock_ms;
        q.rx_start = iec104_pkg::START_OCTET;
        q.rx_length = 4;
        q.tx_asdu_length = 1;
        q.tx_function = 8'h43;
        return q;
    endfunction

    // mostly a well-formed conversation, some noise
    function automatic iec104_pkg::t_req pick_req();
        iec104_pkg::t_req q;
        logic [7:0] fns[6] = '{8'h07, 8'h0B, 8'h13, 8'h23, 8'h43, 8'h83};
        logic [14:0] s, r;
        int pick;
        clock_ms += ($urandom_range(9) == 0) ? $urandom_range(40000) : $urandom_range(2000);
        q = blank_req(iec104_pkg::REQ_RX);
        pick = $urandom_range(99);
        if (pick < 30) begin
            s = link_sb.recv_seq;
            r = link_sb.acked_seq + 15'($urandom_range(link_sb.in_flight()));
            if ($urandom_range(9) == 0) s = 15'($urandom);
            if ($urandom_range(19) == 0) r = 15'($urandom);
            q.rx_length = 8'(4 + $urandom_range(249));
            q.rx_control = {r, 1'b0, s, 1'b0};
        end else if (pick < 42) begin
            r = link_sb.acked_seq + 15'($urandom_range(link_sb.in_flight()));
            if ($urandom_range(9) == 0) r = 15'($urandom);
            q.rx_control = {r, 1'b0, 8'($urandom), 8'h01};
        end else if (pick < 50) begin
            q.rx_control = {24'($urandom), fns[$urandom_range(5)]};
        end else if (pick < 70) begin
            q.req_type = iec104_pkg::REQ_SEND_I;
            q.tx_asdu_length = 8'(1 + $urandom_range(248));
        end else if (pick < 76) begin
            q.req_type = iec104_pkg::REQ_SEND_S;
        end else if (pick < 84) begin
            q.req_type = iec104_pkg::REQ_SEND_U;
            q.tx_function = ($urandom_range(4) == 0) ? 8'($urandom) : fns[$urandom_range(5)];
        end else if (pick < 90) begin
            q.req_type = 3'($urandom_range(4, 7));
            if (q.req_type == iec104_pkg::REQ_RESET && $urandom_range(3) != 0)
                q.req_type = iec104_pkg::REQ_TIMER;
        end else begin
            q = iec104_pkg::t_req'($bits(iec104_pkg::t_req)'({$urandom, $urandom,
                                                              $urandom, $urandom}));
            q.req_type = (q.req_type == iec104_pkg::REQ_RESET) ? iec104_pkg::REQ_RX
                                                               : q.req_type;
            if ($urandom_range(1)) q.rx_start = iec104_pkg::START_OCTET;
            q.now_ms = clock_ms;
        end
        return q;
    endfunction

    initial begin
        iec104_pkg::t_req q;
        logic [7:0] fns[6] = '{8'h07, 8'h0B, 8'h13, 8'h23, 8'h43, 8'h83};
        link_sb = new();
        link_sb.power_on();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = 0; i_cfg_data = 0;
        req_if.valid = 0; req_if.data = '0;
        src_idle_pct = 0; snk_stall_pct = 0; quiet_cycles = 0;
        clock_ms = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every request kind and the edge cases
        q = blank_req(iec104_pkg::REQ_RX); q.rx_start = 8'h67; send_req(q);
        q = blank_req(iec104_pkg::REQ_RX); q.rx_length = 3; send_req(q);
        q = blank_req(iec104_pkg::REQ_RX); q.rx_length = 254; send_req(q);
        q = blank_req(iec104_pkg::REQ_RX); q.rx_length = 253; q.rx_control = 32'h0;
        send_req(q);
        q = blank_req(iec104_pkg::REQ_RX); q.rx_length = 5; q.rx_control = 32'h1;
        send_req(q);
        q = blank_req(iec104_pkg::REQ_RX); q.rx_control = 32'h0000_0013; send_req(q);
        q = blank_req(iec104_pkg::REQ_RX); q.rx_control = 32'hFFFF_FF33; send_req(q);
        q = blank_req(iec104_pkg::REQ_RX); q.rx_control = 32'h0002_0002; send_req(q);
        q = blank_req(iec104_pkg::REQ_SEND_I); q.tx_asdu_length = 0; send_req(q);
        q = blank_req(iec104_pkg::REQ_SEND_I); q.tx_asdu_length = 250; send_req(q);
        q = blank_req(iec104_pkg::REQ_SEND_I); q.tx_asdu_length = 249; send_req(q);
        q = blank_req(iec104_pkg::REQ_SEND_I); q.tx_asdu_length = 255; send_req(q);
        q = blank_req(iec104_pkg::REQ_SEND_S); send_req(q);
        q = blank_req(iec104_pkg::REQ_SEND_U); q.tx_function = 8'hFF; send_req(q);
        foreach (fns[i]) begin
            q = blank_req(iec104_pkg::REQ_SEND_U); q.tx_function = fns[i]; send_req(q);
        end
        // unused request codes behave as a timer check
        q = blank_req(3'd6); q.now_ms = 32'hFFFF_FFFF; send_req(q);
        q = blank_req(3'd7); q.now_ms = 32'h0000_0005; send_req(q);
        q = blank_req(iec104_pkg::REQ_RESET); send_req(q);
        q = blank_req(iec104_pkg::REQ_TIMER); q.now_ms = 32'd300000; send_req(q);
        drain();

        // random phases, each under its own settings and one of four idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_cfg(iec104_pkg::CFG_K, 1); write_cfg(iec104_pkg::CFG_W, 1);
                         write_cfg(iec104_pkg::CFG_T1, 1); write_cfg(iec104_pkg::CFG_T2, 1);
                         write_cfg(iec104_pkg::CFG_T3, 1); end
                1: begin write_cfg(iec104_pkg::CFG_K, 32767);
                         write_cfg(iec104_pkg::CFG_W, 32767);
                         write_cfg(iec104_pkg::CFG_T1, 255000);
                         write_cfg(iec104_pkg::CFG_T2, 255000);
                         write_cfg(iec104_pkg::CFG_T3, 255000); end
                2: begin write_cfg(iec104_pkg::CFG_K, 0); write_cfg(iec104_pkg::CFG_W, 0);
                         write_cfg(iec104_pkg::CFG_T1, 0); write_cfg(iec104_pkg::CFG_T2, 0);
                         write_cfg(iec104_pkg::CFG_T3, 0); end
                3: begin write_cfg(iec104_pkg::CFG_K, 18'h3FFFF);
                         write_cfg(iec104_pkg::CFG_T1, 18'h3FFFF);
                         write_cfg(iec104_pkg::CFG_T2, 18'h3FFFF);
                         write_cfg(iec104_pkg::CFG_T3, 18'h3FFFF); end
                default: begin
                    write_cfg(iec104_pkg::CFG_K, 18'(1 + $urandom_range(20)));
                    write_cfg(iec104_pkg::CFG_W, 18'($urandom_range(25)));
                    write_cfg(iec104_pkg::CFG_T1, 18'($urandom_range(30000)));
                    write_cfg(iec104_pkg::CFG_T2, 18'($urandom_range(30000)));
                    write_cfg(iec104_pkg::CFG_T3, 18'($urandom_range(40000)));
                end
            endcase
            src_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 13 : 66) : 0;
            snk_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 13 : 66) : 0;
            for (int n = 0; n < 190; n++) begin
                send_req(pick_req());
                if (n == 95) drain();
            end
            drain();
        end
        drain();
        if (link_sb.errors == 0 && link_sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
